FILE: design/sbd_pkg.sv
// Shared types and constants for the script bytecode decoder.
// Used by sbd_front, sbd_back and script_bytecode_decoder.
package sbd_pkg;

   localparam int NATIVE_DEPTH_DEFAULT = 1024;
   localparam int QUEUE_DEPTH_DEFAULT  = 4;

   localparam logic [7:0] OPCODE_MAX = 8'd126;
   localparam int         CASE_BYTES = 6;

   // Opcodes with special operand handling
   localparam logic [6:0] OP_PUSH_B      = 7'd37;
   localparam logic [6:0] OP_PUSH_BB     = 7'd38;
   localparam logic [6:0] OP_PUSH_BBB    = 7'd39;
   localparam logic [6:0] OP_PUSH_D      = 7'd40;
   localparam logic [6:0] OP_PUSH_F      = 7'd41;
   localparam logic [6:0] OP_NATIVE      = 7'd44;
   localparam logic [6:0] OP_ENTER       = 7'd45;
   localparam logic [6:0] OP_LEAVE       = 7'd46;
   localparam logic [6:0] OP_BYTE_LO_A   = 7'd52;
   localparam logic [6:0] OP_BYTE_HI_A   = 7'd62;
   localparam logic [6:0] OP_BYTE_LO_B   = 7'd64;
   localparam logic [6:0] OP_BYTE_HI_B   = 7'd66;
   localparam logic [6:0] OP_WORD_LO     = 7'd67;
   localparam logic [6:0] OP_WORD_HI     = 7'd83;
   localparam logic [6:0] OP_JUMP_LO     = 7'd85;
   localparam logic [6:0] OP_JUMP_HI     = 7'd92;
   localparam logic [6:0] OP_TRIPLE_LO   = 7'd93;
   localparam logic [6:0] OP_TRIPLE_HI   = 7'd97;
   localparam logic [6:0] OP_SWITCH      = 7'd98;
   localparam logic [6:0] OP_BYTE_LO_C   = 7'd101;
   localparam logic [6:0] OP_BYTE_HI_C   = 7'd104;

   // Instruction length by opcode; the last entry is never used
   localparam logic [2:0] OP_LEN [128] = '{
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4,
      3'd5, 3'd5, 3'd1, 3'd1, 3'd4, 3'd5, 3'd3, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4,
      3'd4, 3'd4, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2,
      3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
   };

   typedef enum logic [1:0] {
      KIND_INSTR = 2'd0,
      KIND_CASE  = 2'd1,
      KIND_ERROR = 2'd2
   } sbd_kind_type;

   typedef struct packed {
      sbd_kind_type kind;
      logic [31:0]  address;
      logic [7:0]   opcode;
      logic [10:0]  length;
      logic [31:0]  operand_a;
      logic [7:0]   operand_b;
      logic [7:0]   operand_c;
      logic [31:0]  jump_target;
      logic [15:0]  native_index;
      logic [63:0]  native_hash;
      logic         native_missing;
   } sbd_result_type;

   // One word from front to back: a result to finish, a table write, or both idle
   typedef struct packed {
      logic           has_result;
      logic           need_hash;
      logic [5:0]     rotate;
      logic           wr_en;
      logic [15:0]    wr_addr;
      logic [63:0]    wr_word;
      sbd_result_type res;
   } sbd_cmd_type;

endpackage

FILE: design/script_bytecode_decoder.sv
// Script bytecode decoder: one code byte or native table write per cycle while req_full is
// low. A result passes the command queue, the back-end stage and the result queue
// to the rsp_ ports. Throughput: one item per cycle unless stalled, set by the
// single native table port (one write or one read per cycle) in the back end.
// Reset: synchronous; clears position tracking, halt flag, queues and code_size;
// the native table is not cleared.
module script_bytecode_decoder #(
   parameter int NativeDepth = sbd_pkg::NATIVE_DEPTH_DEFAULT,
   parameter int QueueDepth  = sbd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_command,
   input  logic [7:0]  req_code_byte,
   input  logic [9:0]  req_native_slot,
   input  logic [63:0] req_native_word,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_address,
   output logic [7:0]  rsp_opcode,
   output logic [10:0] rsp_length,
   output logic [31:0] rsp_operand_a,
   output logic [7:0]  rsp_operand_b,
   output logic [7:0]  rsp_operand_c,
   output logic [31:0] rsp_jump_target,
   output logic [15:0] rsp_native_index,
   output logic [63:0] rsp_native_hash,
   output logic        rsp_native_missing,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   import sbd_pkg::*;

   localparam int CmdWidth = $bits(sbd_cmd_type);

   logic [31:0]         code_size_ff;
   logic                accept;
   logic                cmd_push;
   sbd_cmd_type         cmd_in;
   logic                mid_full;
   logic                mid_empty;
   logic                mid_pop;
   logic [CmdWidth-1:0] mid_data;
   sbd_result_type      rsp_head;

   assign accept   = req_push && !req_full;
   assign req_full = mid_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_size_ff <= '0;
      end else if (csr_we) begin
         code_size_ff <= csr_wdata;
      end
   end

   sbd_front #(
      .NativeDepth (NativeDepth)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_command),
      .code_byte   (req_code_byte),
      .native_slot (req_native_slot),
      .native_word (req_native_word),
      .code_size   (code_size_ff),
      .cmd_push    (cmd_push),
      .cmd_out     (cmd_in)
   );

   sbd_fifo #(
      .Width (CmdWidth),
      .Depth (QueueDepth)
   ) u_mid_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .data_in  (cmd_in),
      .full     (mid_full),
      .pop      (mid_pop),
      .data_out (mid_data),
      .empty    (mid_empty)
   );

   sbd_back #(
      .NativeDepth (NativeDepth),
      .QueueDepth  (QueueDepth)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (sbd_cmd_type'(mid_data)),
      .cmd_empty (mid_empty),
      .cmd_pop   (mid_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_head  (rsp_head)
   );

   assign rsp_kind           = rsp_head.kind;
   assign rsp_address        = rsp_head.address;
   assign rsp_opcode         = rsp_head.opcode;
   assign rsp_length         = rsp_head.length;
   assign rsp_operand_a      = rsp_head.operand_a;
   assign rsp_operand_b      = rsp_head.operand_b;
   assign rsp_operand_c      = rsp_head.operand_c;
   assign rsp_jump_target    = rsp_head.jump_target;
   assign rsp_native_index   = rsp_head.native_index;
   assign rsp_native_hash    = rsp_head.native_hash;
   assign rsp_native_missing = rsp_head.native_missing;

endmodule

FILE: design/sbd_fifo.sv
// Small register-based first-in first-out queue of plain bit vectors.
// Depends on nothing; used between front and back and at the result side.
module sbd_fifo #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] data_out,
   output logic             empty
);
   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   logic [Width-1:0]      store_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CountWidth'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

FILE: design/sbd_front.sv
// Front end: tracks instruction boundaries in the byte stream, gathers operands
// and classifies each finished instruction. Depends on sbd_pkg.
module sbd_front #(
   parameter int NativeDepth = sbd_pkg::NATIVE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               command,
   input  logic [7:0]         code_byte,
   input  logic [9:0]         native_slot,
   input  logic [63:0]        native_word,
   input  logic [31:0]        code_size,
   output logic               cmd_push,
   output sbd_pkg::sbd_cmd_type cmd_out
);
   import sbd_pkg::*;

   localparam logic [2:0] POS_OPCODE = 3'd0;
   localparam logic [2:0] POS_COUNT  = 3'd1;
   localparam logic [2:0] POS_CASES  = 3'd2;

   logic [31:0] byte_address_ff, byte_address_in;
   logic [31:0] instr_start_ff, instr_start_in;
   logic [2:0]  pos_ff, pos_in;
   logic [6:0]  held_opcode_ff, held_opcode_in;
   logic [2:0]  instr_len_ff, instr_len_in;
   logic [47:0] shift_ff, shift_in;
   logic [7:0]  cases_left_ff, cases_left_in;
   logic [31:0] case_start_ff, case_start_in;
   logic [2:0]  case_byte_ff, case_byte_in;
   logic        halted_ff, halted_in;

   logic [2:0]  pos_m1;
   logic [31:0] operand_new;
   logic [2:0]  first_len;

   function automatic logic [31:0] rel_target(input logic [31:0] end_addr,
                                              input logic [15:0] off);
      return end_addr + {{16{off[15]}}, off};
   endfunction

   function automatic sbd_cmd_type decode_instr(input logic [6:0]  op,
                                                input logic [31:0] v,
                                                input logic [31:0] start,
                                                input logic [2:0]  len,
                                                input logic [31:0] csize);
      sbd_cmd_type c;
      logic [15:0] idx;
      c = '0;
      idx = {v[15:8], v[23:16]};
      c.has_result   = 1'b1;
      c.res.kind     = KIND_INSTR;
      c.res.address  = start;
      c.res.opcode   = {1'b0, op};
      c.res.length   = {8'b0, len};
      if (op == OP_PUSH_B || op == OP_ENTER || op == OP_LEAVE
          || (op >= OP_BYTE_LO_A && op <= OP_BYTE_HI_A)
          || (op >= OP_BYTE_LO_B && op <= OP_BYTE_HI_B)
          || (op >= OP_BYTE_LO_C && op <= OP_BYTE_HI_C)) begin
         c.res.operand_a = {24'b0, v[7:0]};
         if (op == OP_ENTER || op == OP_LEAVE) begin
            c.res.operand_b = v[15:8];
         end
      end else if (op == OP_PUSH_BB) begin
         c.res.operand_a = {24'b0, v[7:0]};
         c.res.operand_b = v[15:8];
      end else if (op == OP_PUSH_BBB) begin
         c.res.operand_a = {24'b0, v[7:0]};
         c.res.operand_b = v[15:8];
         c.res.operand_c = v[23:16];
      end else if (op == OP_PUSH_D || op == OP_PUSH_F) begin
         c.res.operand_a = v;
      end else if (op >= OP_WORD_LO && op <= OP_WORD_HI) begin
         c.res.operand_a = {16'b0, v[15:0]};
      end else if (op >= OP_TRIPLE_LO && op <= OP_TRIPLE_HI) begin
         c.res.operand_a = {8'b0, v[23:0]};
      end else if (op >= OP_JUMP_LO && op <= OP_JUMP_HI) begin
         c.res.jump_target = rel_target(start + 32'd3, v[15:0]);
      end else if (op == OP_NATIVE) begin
         c.res.operand_a    = {26'b0, v[7:2]};
         c.res.operand_b    = {6'b0, v[1:0]};
         c.res.native_index = idx;
         if ({16'b0, idx} < 32'(NativeDepth)) begin
            c.need_hash = 1'b1;
            c.rotate    = idx[5:0] + csize[5:0];
         end else begin
            c.res.native_missing = 1'b1;
         end
      end else begin
         c.res.operand_a = '0;
      end
      return c;
   endfunction

   assign pos_m1      = pos_ff - 3'd1;
   assign operand_new = shift_ff[31:0] | (32'(code_byte) << {pos_m1, 3'b000});
   assign first_len   = OP_LEN[code_byte[6:0]];

   always_comb begin
      byte_address_in = byte_address_ff;
      instr_start_in  = instr_start_ff;
      pos_in          = pos_ff;
      held_opcode_in  = held_opcode_ff;
      instr_len_in    = instr_len_ff;
      shift_in        = shift_ff;
      cases_left_in   = cases_left_ff;
      case_start_in   = case_start_ff;
      case_byte_in    = case_byte_ff;
      halted_in       = halted_ff;
      cmd_push        = 1'b0;
      cmd_out         = '0;
      if (accept && command) begin
         // drop writes beyond the table
         if ({22'b0, native_slot} < 32'(NativeDepth)) begin
            cmd_push        = 1'b1;
            cmd_out.wr_en   = 1'b1;
            cmd_out.wr_addr = {6'b0, native_slot};
            cmd_out.wr_word = native_word;
         end
      end else if (accept && !halted_ff) begin
         byte_address_in = byte_address_ff + 32'd1;
         if (pos_ff == POS_OPCODE) begin
            instr_start_in = byte_address_ff;
            if (code_byte > OPCODE_MAX) begin
               halted_in              = 1'b1;
               cmd_push               = 1'b1;
               cmd_out.has_result     = 1'b1;
               cmd_out.res.kind       = KIND_ERROR;
               cmd_out.res.address    = byte_address_ff;
               cmd_out.res.opcode     = code_byte;
               cmd_out.res.length     = 11'd1;
            end else begin
               held_opcode_in = code_byte[6:0];
               instr_len_in   = first_len;
               shift_in       = '0;
               if (first_len == 3'd1) begin
                  cmd_push = 1'b1;
                  cmd_out  = decode_instr(code_byte[6:0], '0, byte_address_ff, 3'd1,
                                          code_size);
               end else begin
                  pos_in = POS_COUNT;
               end
            end
         end else if (held_opcode_ff == OP_SWITCH) begin
            if (pos_ff == POS_COUNT) begin
               cmd_push              = 1'b1;
               cmd_out.has_result    = 1'b1;
               cmd_out.res.kind      = KIND_INSTR;
               cmd_out.res.address   = instr_start_ff;
               cmd_out.res.opcode    = {1'b0, OP_SWITCH};
               cmd_out.res.length    = 11'd2 + ({3'b0, code_byte} << 2)
                                       + ({3'b0, code_byte} << 1);
               cmd_out.res.operand_a = {24'b0, code_byte};
               shift_in              = '0;
               case_start_in         = byte_address_ff + 32'd1;
               cases_left_in         = code_byte;
               case_byte_in          = '0;
               pos_in                = (code_byte == 8'd0) ? POS_OPCODE : POS_CASES;
            end else begin
               shift_in = shift_ff | (48'(code_byte) << {case_byte_ff, 3'b000});
               if (case_byte_ff == 3'(CASE_BYTES - 1)) begin
                  cmd_push                = 1'b1;
                  cmd_out.has_result      = 1'b1;
                  cmd_out.res.kind        = KIND_CASE;
                  cmd_out.res.address     = case_start_ff;
                  cmd_out.res.opcode      = {1'b0, OP_SWITCH};
                  cmd_out.res.length      = 11'(CASE_BYTES);
                  cmd_out.res.operand_a   = shift_ff[31:0];
                  cmd_out.res.jump_target = rel_target(case_start_ff + 32'(CASE_BYTES),
                                                       {code_byte, shift_ff[39:32]});
                  shift_in      = '0;
                  case_start_in = byte_address_ff + 32'd1;
                  cases_left_in = cases_left_ff - 8'd1;
                  case_byte_in  = '0;
                  if (cases_left_ff == 8'd1) begin
                     pos_in = POS_OPCODE;
                  end
               end else begin
                  case_byte_in = case_byte_ff + 3'd1;
               end
            end
         end else begin
            shift_in = {16'b0, operand_new};
            if ((pos_ff + 3'd1) >= instr_len_ff) begin
               pos_in   = POS_OPCODE;
               cmd_push = 1'b1;
               cmd_out  = decode_instr(held_opcode_ff, operand_new, instr_start_ff,
                                       instr_len_ff, code_size);
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_address_ff <= '0;
         instr_start_ff  <= '0;
         pos_ff          <= POS_OPCODE;
         held_opcode_ff  <= '0;
         instr_len_ff    <= '0;
         shift_ff        <= '0;
         cases_left_ff   <= '0;
         case_start_ff   <= '0;
         case_byte_ff    <= '0;
         halted_ff       <= 1'b0;
      end else begin
         byte_address_ff <= byte_address_in;
         instr_start_ff  <= instr_start_in;
         pos_ff          <= pos_in;
         held_opcode_ff  <= held_opcode_in;
         instr_len_ff    <= instr_len_in;
         shift_ff        <= shift_in;
         cases_left_ff   <= cases_left_in;
         case_start_ff   <= case_start_in;
         case_byte_ff    <= case_byte_in;
         halted_ff       <= halted_in;
      end
   end

endmodule

FILE: design/sbd_back.sv
// Back end: applies native table writes, looks up and rotates native hashes,
// and queues finished results. Depends on sbd_pkg and sbd_fifo.
module sbd_back #(
   parameter int NativeDepth = sbd_pkg::NATIVE_DEPTH_DEFAULT,
   parameter int QueueDepth  = sbd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sbd_pkg::sbd_cmd_type   cmd_head,
   input  logic                   cmd_empty,
   output logic                   cmd_pop,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output sbd_pkg::sbd_result_type rsp_head
);
   import sbd_pkg::*;

   localparam int AddrWidth   = (NativeDepth > 1) ? $clog2(NativeDepth) : 1;
   localparam int ResultWidth = $bits(sbd_result_type);

   logic [63:0]      native_mem [NativeDepth];
   logic [63:0]      rd_data_ff;
   sbd_cmd_type      stage_ff;
   logic             stage_valid_ff, stage_valid_in;
   logic             out_full;
   logic             out_push;
   logic [127:0]     rotated;
   sbd_result_type   stage_result;
   logic [ResultWidth-1:0] out_data;

   assign out_push = stage_valid_ff && !out_full;
   assign cmd_pop  = !cmd_empty && (!stage_valid_ff || !out_full);

   // rotate left: upper half of the doubled word shifted by the amount
   assign rotated = {rd_data_ff, rd_data_ff} << stage_ff.rotate;

   always_comb begin
      stage_result             = stage_ff.res;
      stage_result.native_hash = stage_ff.need_hash ? rotated[127:64] : 64'd0;
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (cmd_pop) begin
         stage_valid_in = cmd_head.has_result;
      end else if (out_push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd_head.wr_en) begin
         native_mem[cmd_head.wr_addr[AddrWidth-1:0]] <= cmd_head.wr_word;
      end
      if (cmd_pop && cmd_head.need_hash) begin
         rd_data_ff <= native_mem[cmd_head.res.native_index[AddrWidth-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         stage_ff <= cmd_head;
      end
   end

   sbd_fifo #(
      .Width (ResultWidth),
      .Depth (QueueDepth)
   ) u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .data_in  (stage_result),
      .full     (out_full),
      .pop      (rsp_pop),
      .data_out (out_data),
      .empty    (rsp_empty)
   );

   assign rsp_head = sbd_result_type'(out_data);

endmodule

FILE: dv/sbd_decode_checker.sv
`timescale 1ns / 100ps
// Decode checker for the script bytecode decoder: predicts every rsp_ word from
// the accepted req_ words and csr_ writes, and compares it field by field.
// Depends on sbd_pkg for result kinds, opcode names and the native table depth.
module sbd_decode_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_command,
   input  logic [7:0]  req_code_byte,
   input  logic [9:0]  req_native_slot,
   input  logic [63:0] req_native_word,
   input  logic        rsp_pop,
   input  logic        rsp_empty,
   input  logic [1:0]  rsp_kind,
   input  logic [31:0] rsp_address,
   input  logic [7:0]  rsp_opcode,
   input  logic [10:0] rsp_length,
   input  logic [31:0] rsp_operand_a,
   input  logic [7:0]  rsp_operand_b,
   input  logic [7:0]  rsp_operand_c,
   input  logic [31:0] rsp_jump_target,
   input  logic [15:0] rsp_native_index,
   input  logic [63:0] rsp_native_hash,
   input  logic        rsp_native_missing,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output int          mismatches,
   output int          decodes_due
);
   import sbd_pkg::*;

   localparam int NATIVE_SLOTS = NATIVE_DEPTH_DEFAULT;
   localparam int REPORT_LIMIT = 40;

   logic [31:0]    code_size;
   logic [31:0]    byte_addr;
   logic [31:0]    instr_addr;
   logic [31:0]    case_addr;
   logic [6:0]     held_op;
   logic [63:0]    operand_bits;
   int unsigned    byte_pos;
   int unsigned    instr_len;
   int unsigned    cases_left;
   bit             halted;
   logic [63:0]    native_mem [NATIVE_SLOTS];
   sbd_result_type expected_decodes [$];

   function automatic int unsigned decoded_length(input logic [6:0] op);
      if (op == OP_PUSH_B || op == OP_SWITCH ||
          (op >= OP_BYTE_LO_A && op <= OP_BYTE_HI_A) ||
          (op >= OP_BYTE_LO_B && op <= OP_BYTE_HI_B) ||
          (op >= OP_BYTE_LO_C && op <= OP_BYTE_HI_C))
         return 2;
      if (op == OP_PUSH_BB || op == OP_LEAVE || (op >= OP_WORD_LO && op <= OP_JUMP_HI))
         return 3;
      if (op == OP_PUSH_BBB || op == OP_NATIVE || (op >= OP_TRIPLE_LO && op <= OP_TRIPLE_HI))
         return 4;
      if (op == OP_PUSH_D || op == OP_PUSH_F || op == OP_ENTER)
         return 5;
      return 1;
   endfunction

   function automatic logic [31:0] rel_target(input logic [31:0] end_addr,
                                              input logic [15:0] offset);
      return end_addr + {{16{offset[15]}}, offset};
   endfunction

   function automatic sbd_result_type finish_instr(input logic [6:0]  op,
                                                   input logic [31:0] start,
                                                   input int unsigned len,
                                                   input logic [63:0] bits);
      sbd_result_type r;
      logic [15:0]    idx;
      logic [63:0]    h;
      logic [5:0]     rot;
      r = '0;
      r.kind    = KIND_INSTR;
      r.address = start;
      r.opcode  = {1'b0, op};
      r.length  = 11'(len);
      if (op == OP_PUSH_B || op == OP_ENTER || op == OP_LEAVE ||
          (op >= OP_BYTE_LO_A && op <= OP_BYTE_HI_A) ||
          (op >= OP_BYTE_LO_B && op <= OP_BYTE_HI_B) ||
          (op >= OP_BYTE_LO_C && op <= OP_BYTE_HI_C)) begin
         r.operand_a = {24'b0, bits[7:0]};
         if (op == OP_ENTER || op == OP_LEAVE)
            r.operand_b = bits[15:8];
      end else if (op == OP_PUSH_BB) begin
         r.operand_a = {24'b0, bits[7:0]};
         r.operand_b = bits[15:8];
      end else if (op == OP_PUSH_BBB) begin
         r.operand_a = {24'b0, bits[7:0]};
         r.operand_b = bits[15:8];
         r.operand_c = bits[23:16];
      end else if (op == OP_PUSH_D || op == OP_PUSH_F) begin
         r.operand_a = bits[31:0];
      end else if (op >= OP_WORD_LO && op <= OP_WORD_HI) begin
         r.operand_a = {16'b0, bits[15:0]};
      end else if (op >= OP_TRIPLE_LO && op <= OP_TRIPLE_HI) begin
         r.operand_a = {8'b0, bits[23:0]};
      end else if (op >= OP_JUMP_LO && op <= OP_JUMP_HI) begin
         r.jump_target = rel_target(start + 32'd3, bits[15:0]);
      end else if (op == OP_NATIVE) begin
         // index is big-endian, unlike every other operand
         idx = {bits[15:8], bits[23:16]};
         r.operand_a    = {26'b0, bits[7:2]};
         r.operand_b    = {6'b0, bits[1:0]};
         r.native_index = idx;
         if (int'(idx) < NATIVE_SLOTS) begin
            h   = native_mem[idx];
            rot = idx[5:0] + code_size[5:0];
            r.native_hash = (rot == 6'd0) ? h : ((h << rot) | (h >> (7'd64 - {1'b0, rot})));
         end else begin
            r.native_missing = 1'b1;
         end
      end
      return r;
   endfunction

   task automatic decode_byte(input logic cmd, input logic [7:0] b,
                              input logic [9:0] slot, input logic [63:0] word);
      logic [31:0]    addr;
      int unsigned    k;
      sbd_result_type r;
      if (cmd) begin
         native_mem[slot] = word;
         return;
      end
      if (halted)
         return;
      addr      = byte_addr;
      byte_addr = addr + 32'd1;

      if (byte_pos == 0) begin
         instr_addr = addr;
         if (b > OPCODE_MAX) begin
            // unknown opcode: report it and stop decoding until reset
            halted    = 1'b1;
            r         = '0;
            r.kind    = KIND_ERROR;
            r.address = addr;
            r.opcode  = b;
            r.length  = 11'd1;
            expected_decodes.push_back(r);
            return;
         end
         held_op      = b[6:0];
         instr_len    = decoded_length(held_op);
         operand_bits = '0;
         if (instr_len == 1)
            expected_decodes.push_back(finish_instr(held_op, instr_addr, 1, '0));
         else
            byte_pos = 1;
         return;
      end

      if (held_op == OP_SWITCH) begin
         if (byte_pos == 1) begin
            // count byte: emit the switch itself with its full length
            instr_len    = 2 + CASE_BYTES * int'(b);
            cases_left   = b;
            r            = '0;
            r.kind       = KIND_INSTR;
            r.address    = instr_addr;
            r.opcode     = {1'b0, OP_SWITCH};
            r.length     = 11'(instr_len);
            r.operand_a  = {24'b0, b};
            operand_bits = '0;
            case_addr    = addr + 32'd1;
            byte_pos     = (b == 8'd0) ? 0 : 2;
            expected_decodes.push_back(r);
            return;
         end
         k = (byte_pos - 2) % CASE_BYTES;
         operand_bits |= 64'(b) << (8 * k);
         byte_pos++;
         if (k != CASE_BYTES - 1)
            return;
         r             = '0;
         r.kind        = KIND_CASE;
         r.address     = case_addr;
         r.opcode      = {1'b0, OP_SWITCH};
         r.length      = 11'(CASE_BYTES);
         r.operand_a   = operand_bits[31:0];
         r.jump_target = rel_target(case_addr + CASE_BYTES, operand_bits[47:32]);
         expected_decodes.push_back(r);
         operand_bits = '0;
         case_addr    = addr + 32'd1;
         cases_left--;
         if (cases_left == 0)
            byte_pos = 0;
         return;
      end

      operand_bits |= 64'(b) << (8 * ((byte_pos - 1) & 7));
      byte_pos++;
      if (byte_pos < instr_len)
         return;
      byte_pos = 0;
      expected_decodes.push_back(finish_instr(held_op, instr_addr, instr_len, operand_bits));
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      // cap the log, keep counting
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch({name, " mismatch"}, got, want);
   endtask

   task automatic check_decode();
      sbd_result_type want;
      if (expected_decodes.size() == 0) begin
         report_mismatch("unexpected rsp word at address", 64'(rsp_address), '0);
         return;
      end
      want = expected_decodes.pop_front();
      compare_field("kind",           64'(rsp_kind),           64'(want.kind));
      compare_field("address",        64'(rsp_address),        64'(want.address));
      compare_field("opcode",         64'(rsp_opcode),         64'(want.opcode));
      compare_field("length",         64'(rsp_length),         64'(want.length));
      compare_field("operand_a",      64'(rsp_operand_a),      64'(want.operand_a));
      compare_field("operand_b",      64'(rsp_operand_b),      64'(want.operand_b));
      compare_field("operand_c",      64'(rsp_operand_c),      64'(want.operand_c));
      compare_field("jump_target",    64'(rsp_jump_target),    64'(want.jump_target));
      compare_field("native_index",   64'(rsp_native_index),   64'(want.native_index));
      compare_field("native_hash",    rsp_native_hash,         want.native_hash);
      compare_field("native_missing", 64'(rsp_native_missing), 64'(want.native_missing));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         code_size    = '0;
         byte_addr    = '0;
         instr_addr   = '0;
         case_addr    = '0;
         held_op      = '0;
         operand_bits = '0;
         byte_pos     = 0;
         instr_len    = 0;
         cases_left   = 0;
         halted       = 1'b0;
         expected_decodes.delete();
      end else begin
         if (csr_we)
            code_size = csr_wdata;
         if (req_push && !req_full)
            decode_byte(req_command, req_code_byte, req_native_slot, req_native_word);
         if (rsp_pop && !rsp_empty)
            check_decode();
      end
      decodes_due = expected_decodes.size();
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Top of the script bytecode decoder testbench: clock, reset, code and native
// table stimulus, rsp_ flow control and the verdict. Needs sbd_pkg and sbd_decode_checker.
module tb_top;
   import sbd_pkg::*;

   localparam int RESET_CYCLES   = 7;
   localparam int DRAIN_CYCLES   = 6;
   localparam int END_CYCLES     = 12;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_WORDS    = 170;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_command;
   logic [7:0]  req_code_byte;
   logic [9:0]  req_native_slot;
   logic [63:0] req_native_word;
   logic        rsp_pop;
   logic        rsp_empty;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_address;
   logic [7:0]  rsp_opcode;
   logic [10:0] rsp_length;
   logic [31:0] rsp_operand_a;
   logic [7:0]  rsp_operand_b;
   logic [7:0]  rsp_operand_c;
   logic [31:0] rsp_jump_target;
   logic [15:0] rsp_native_index;
   logic [63:0] rsp_native_hash;
   logic        rsp_native_missing;
   logic        csr_we;
   logic [31:0] csr_wdata;

   int mismatches;
   int decodes_due;
   int quiet_cycles;
   int sent;
   bit steady;
   bit hold_rsp;
   bit slot_written [NATIVE_DEPTH_DEFAULT];
   int written_slots [$];

   script_bytecode_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_command        (req_command),
      .req_code_byte      (req_code_byte),
      .req_native_slot    (req_native_slot),
      .req_native_word    (req_native_word),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_kind           (rsp_kind),
      .rsp_address        (rsp_address),
      .rsp_opcode         (rsp_opcode),
      .rsp_length         (rsp_length),
      .rsp_operand_a      (rsp_operand_a),
      .rsp_operand_b      (rsp_operand_b),
      .rsp_operand_c      (rsp_operand_c),
      .rsp_jump_target    (rsp_jump_target),
      .rsp_native_index   (rsp_native_index),
      .rsp_native_hash    (rsp_native_hash),
      .rsp_native_missing (rsp_native_missing),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   sbd_decode_checker decode_check (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_command        (req_command),
      .req_code_byte      (req_code_byte),
      .req_native_slot    (req_native_slot),
      .req_native_word    (req_native_word),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_kind           (rsp_kind),
      .rsp_address        (rsp_address),
      .rsp_opcode         (rsp_opcode),
      .rsp_length         (rsp_length),
      .rsp_operand_a      (rsp_operand_a),
      .rsp_operand_b      (rsp_operand_b),
      .rsp_operand_c      (rsp_operand_c),
      .rsp_jump_target    (rsp_jump_target),
      .rsp_native_index   (rsp_native_index),
      .rsp_native_hash    (rsp_native_hash),
      .rsp_native_missing (rsp_native_missing),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .mismatches         (mismatches),
      .decodes_due        (decodes_due)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // mostly written slots, sometimes an index past the table
   function automatic logic [15:0] pick_index();
      if (written_slots.size() == 0 || $urandom_range(0, 6) == 0)
         return 16'($urandom_range(NATIVE_DEPTH_DEFAULT, 65535));
      return 16'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
   endfunction

   task automatic send_word(input logic cmd, input logic [7:0] b,
                            input logic [9:0] slot, input logic [63:0] word);
      int gap;
      gap = steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push        <= 1'b1;
      req_command     <= cmd;
      req_code_byte   <= b;
      req_native_slot <= slot;
      req_native_word <= word;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sent++;
   endtask

   // don't-care fields carry random bits
   task automatic send_code(input logic [7:0] b);
      send_word(1'b0, b, 10'($urandom), {$urandom, $urandom});
   endtask

   task automatic write_native(input logic [9:0] slot, input logic [63:0] word);
      send_word(1'b1, 8'($urandom), slot, word);
      if (!slot_written[slot]) begin
         slot_written[slot] = 1'b1;
         written_slots.push_back(int'(slot));
      end
   endtask

   task automatic emit_native(input logic [15:0] idx);
      send_code({1'b0, OP_NATIVE});
      send_code(8'($urandom));
      send_code(idx[15:8]);
      send_code(idx[7:0]);
   endtask

   task automatic emit_switch(input logic [7:0] count);
      send_code({1'b0, OP_SWITCH});
      send_code(count);
      repeat (int'(count) * CASE_BYTES) send_code(8'($urandom));
   endtask

   task automatic emit_instr(input logic [6:0] op);
      if (op == OP_NATIVE) begin
         emit_native(pick_index());
      end else if (op == OP_SWITCH) begin
         emit_switch(8'($urandom_range(0, 4)));
      end else begin
         send_code({1'b0, op});
         repeat (int'(OP_LEN[op]) - 1) send_code(8'($urandom));
      end
   endtask

   task automatic emit_random();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         write_native(10'($urandom), pick_word());
      else if (r < 18)
         emit_native(pick_index());
      else if (r < 26)
         emit_switch(8'($urandom_range(0, 4)));
      else
         emit_instr(7'($urandom_range(0, int'(OPCODE_MAX))));
   endtask

   task automatic run_random(input int words);
      int stop;
      stop = sent + words;
      while (sent < stop) emit_random();
   endtask

   // write only with the decoder idle: drop push, drain results, let it settle
   task automatic set_code_size(input logic [31:0] value);
      @(negedge clock);
      req_push <= 1'b0;
      wait (decodes_due == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // result side: random stalls, plus one long hold when asked
   initial begin
      int gap;
      rsp_pop = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         gap = steady ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_push        = 1'b0;
      req_command     = 1'b0;
      req_code_byte   = '0;
      req_native_slot = '0;
      req_native_word = '0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      steady          = 1'b0;
      hold_rsp        = 1'b0;
      sent            = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_code_size('0);
      write_native(10'd0, 64'h0123_4567_89AB_CDEF);
      write_native(10'd1023, '1);
      // jump back past address zero wraps around
      send_code({1'b0, OP_JUMP_LO});
      send_code(8'h00);
      send_code(8'h80);
      emit_native(16'd0);              // rotation by zero
      emit_native(16'd1023);
      emit_native(16'hFFFF);           // beyond the table
      emit_switch(8'd1);
      emit_switch(8'd0);
      send_code(8'd0);
      send_code(OPCODE_MAX);

      set_code_size('1);
      write_native(10'd1, '0);
      run_random(PHASE_WORDS);

      // hold the result side and keep offering words until the input stalls
      set_code_size($urandom);
      hold_rsp = 1'b1;
      steady   = 1'b1;
      run_random(PHASE_WORDS / 2);
      steady   = 1'b0;
      run_random(PHASE_WORDS / 2);

      set_code_size(32'd1);
      steady = 1'b1;
      run_random(PHASE_WORDS);
      steady = 1'b0;

      set_code_size($urandom);
      emit_switch(8'd24);
      run_random(PHASE_WORDS);

      // unknown opcode halts decoding; later code bytes are dropped, writes still land
      send_code(8'($urandom_range(int'(OPCODE_MAX) + 1, 255)));
      repeat (3) send_code(8'($urandom));
      write_native(10'($urandom), pick_word());

      @(negedge clock);
      req_push <= 1'b0;
      wait (decodes_due == 0);
      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
